@@ hw/rtl/skf_pkg.sv @@
// Shared types, constants, saturation helpers and the microcode program of the
// scalar Kalman filter core. Used by every module under hw/rtl.
// No dependencies.
package skf_pkg;

	localparam int WORD_W = 32;
	localparam int FRAC_W = 16;
	localparam int UREG_W = 31;
	localparam int WIDE_W = WORD_W + FRAC_W;
	localparam int STEP_W = 5;
	localparam int IDX_W = 3;
	localparam int OUT_W = 104;
	localparam int OUT_PAD = OUT_W - 3 * WORD_W - 1;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [UREG_W-1:0] ureg_t;

	localparam word_t ONE_FX = word_t'(1 << FRAC_W);
	localparam ureg_t NOISE_RST = ureg_t'(4 << FRAC_W);
	localparam word_t EST_RST = word_t'(14 << FRAC_W);
	localparam ureg_t COV_RST = ureg_t'(6 << FRAC_W);
	localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
	localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};
	localparam logic [WIDE_W-1:0] HALF_LSB = WIDE_W'(1) << (FRAC_W - 1);

	typedef enum logic [IDX_W-1:0] {
		REG_STATE_GAIN    = 3'd0,
		REG_MEASURE_GAIN  = 3'd1,
		REG_PROCESS_NOISE = 3'd2,
		REG_MEASURE_NOISE = 3'd3,
		REG_INIT_ESTIMATE = 3'd4,
		REG_INIT_COV      = 3'd5
	} reg_idx_t;

	typedef struct packed {
		word_t state_gain;
		word_t measure_gain;
		ureg_t process_noise;
		ureg_t measure_noise;
		word_t initial_estimate;
		ureg_t initial_covariance;
	} cfg_t;

	typedef enum logic [3:0] {
		SRC_ZERO, SRC_A, SRC_H, SRC_Q, SRC_R, SRC_Z, SRC_X, SRC_P,
		SRC_XP, SRC_PP, SRC_PH, SRC_S, SRC_K, SRC_T, SRC_IN
	} src_t;

	typedef enum logic [3:0] {
		DST_NONE, DST_XP, DST_T, DST_IN, DST_PP, DST_PH, DST_S, DST_X, DST_P
	} dst_t;

	typedef enum logic [1:0] {
		ALU_PASS, ALU_ADD, ALU_SUB
	} alu_t;

	typedef enum logic [1:0] {
		JMP_NEXT, JMP_WAIT_DIV, JMP_END
	} jmp_t;

	typedef struct packed {
		src_t mul_a;
		src_t mul_b;
		alu_t alu;
		src_t alu_c;
		dst_t dest;
		logic div_start;
		jmp_t jump;
	} ctl_t;

	localparam ctl_t CTL_NOP = '{
		mul_a: SRC_ZERO, mul_b: SRC_ZERO, alu: ALU_PASS, alu_c: SRC_ZERO,
		dest: DST_NONE, div_start: 1'b0, jump: JMP_NEXT
	};

	function automatic logic [WORD_W-1:0] mag(input word_t v);
		return v[WORD_W-1] ? (~v + WORD_W'(1)) : v;
	endfunction

	function automatic word_t sat_mag(input logic [WIDE_W-1:0] m, input logic neg);
		logic [WIDE_W-1:0] lim;
		logic [WORD_W-1:0] r;
		lim = neg ? WIDE_W'({1'b1, {(WORD_W-1){1'b0}}}) : WIDE_W'(WORD_MAX);
		r = (m > lim) ? lim[WORD_W-1:0] : m[WORD_W-1:0];
		return neg ? word_t'(~r + WORD_W'(1)) : word_t'(r);
	endfunction

	// A product issued at a step is registered in prod_s1, then rounded and saturated into r_s2, which feeds the ALU.
	function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
		ctl_t c;
		c = CTL_NOP;
		case (step)
			5'd0: begin c.mul_a = SRC_A; c.mul_b = SRC_X; end
			5'd1: begin c.mul_a = SRC_A; c.mul_b = SRC_P; end
			5'd2: begin c.dest = DST_XP; end
			5'd3: begin c.dest = DST_T; c.mul_a = SRC_H; c.mul_b = SRC_XP; end
			5'd4: begin c.mul_a = SRC_T; c.mul_b = SRC_A; end
			5'd5: begin c.dest = DST_IN; c.alu = ALU_SUB; c.alu_c = SRC_Z; end
			5'd6: begin c.dest = DST_PP; c.alu = ALU_ADD; c.alu_c = SRC_Q; end
			5'd7: begin c.mul_a = SRC_PP; c.mul_b = SRC_H; end
			5'd9: begin c.dest = DST_PH; end
			5'd10: begin c.mul_a = SRC_H; c.mul_b = SRC_PH; end
			5'd12: begin c.dest = DST_S; c.alu = ALU_ADD; c.alu_c = SRC_R; end
			5'd13: begin c.div_start = 1'b1; end
			5'd14: begin c.jump = JMP_WAIT_DIV; end
			5'd15: begin c.mul_a = SRC_K; c.mul_b = SRC_IN; end
			5'd16: begin c.mul_a = SRC_K; c.mul_b = SRC_H; end
			5'd17: begin c.dest = DST_X; c.alu = ALU_ADD; c.alu_c = SRC_XP; end
			5'd18: begin c.dest = DST_T; end
			5'd19: begin c.mul_a = SRC_T; c.mul_b = SRC_PP; end
			5'd21: begin c.dest = DST_P; c.alu = ALU_SUB; c.alu_c = SRC_PP; end
			5'd22: begin c.jump = JMP_END; end
			default: c = CTL_NOP;
		endcase
		return c;
	endfunction

endpackage

@@ hw/rtl/scalar_kalman_filter_core.sv @@
// Scalar Kalman filter core, signed Q16.16. Depends on skf_pkg, skf_seq, skf_dp, skf_div.
// The gain divider runs inside each update; a new measurement is accepted only while
// the sequencer is idle, and the sequencer holds at its end step until the result
// can be registered for output.
// Reset restores the register defaults, estimate 14.0 and covariance 6.0.
module scalar_kalman_filter_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        s_tvalid,
	output logic                        s_tready,
	input  logic [31:0]                 s_tdata,    // measurement
	input  logic [0:0]                  s_tuser,    // restart
	output logic                        m_tvalid,
	input  logic                        m_tready,
	output logic [skf_pkg::OUT_W-1:0]   m_tdata,    // estimate, covariance, gain, divide_fault
	input  logic                        cfg_wr_en,
	input  logic [skf_pkg::IDX_W-1:0]   cfg_index,
	input  logic [skf_pkg::WORD_W-1:0]  cfg_wdata
);
	import skf_pkg::*;

	cfg_t cfg_q;
	ctl_t ctl;
	logic seq_busy, seq_done, div_busy, div_fault, accept, out_hold;
	word_t x, p, ph, s, k;
	logic m_tvalid_q;
	logic [OUT_W-1:0] m_tdata_q;

	assign accept = s_tvalid && s_tready;
	assign s_tready = !seq_busy;
	assign out_hold = m_tvalid_q && !m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.state_gain <= ONE_FX;
			cfg_q.measure_gain <= ONE_FX;
			cfg_q.process_noise <= '0;
			cfg_q.measure_noise <= NOISE_RST;
			cfg_q.initial_estimate <= EST_RST;
			cfg_q.initial_covariance <= COV_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_STATE_GAIN:    cfg_q.state_gain <= cfg_wdata;
				REG_MEASURE_GAIN:  cfg_q.measure_gain <= cfg_wdata;
				REG_PROCESS_NOISE: cfg_q.process_noise <= cfg_wdata[UREG_W-1:0];
				REG_MEASURE_NOISE: cfg_q.measure_noise <= cfg_wdata[UREG_W-1:0];
				REG_INIT_ESTIMATE: cfg_q.initial_estimate <= cfg_wdata;
				REG_INIT_COV:      cfg_q.initial_covariance <= cfg_wdata[UREG_W-1:0];
				default: ;
			endcase
		end
	end

	skf_seq u_seq (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (accept),
		.div_busy (div_busy),
		.out_hold (out_hold),
		.ctl      (ctl),
		.busy     (seq_busy),
		.done     (seq_done)
	);

	skf_dp u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctl         (ctl),
		.cfg         (cfg_q),
		.load        (accept),
		.restart     (s_tuser[0]),
		.measurement (s_tdata),
		.gain        (k),
		.estimate    (x),
		.covariance  (p),
		.ph          (ph),
		.s           (s)
	);

	skf_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctl.div_start),
		.num    (ph),
		.den    (s),
		.busy   (div_busy),
		.quo    (k),
		.fault  (div_fault)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (seq_done) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_done) begin
			m_tdata_q <= {{OUT_PAD{1'b0}}, div_fault, k, p, x};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata = m_tdata_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> seq_busy) else $error("sequencer did not start after a transfer");

	a_fault_zero_gain: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tdata[3*WORD_W]) |-> (m_tdata[3*WORD_W-1:2*WORD_W] == '0))
		else $error("divide fault with nonzero gain");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(seq_done)) else $error("result without program end");

	a_div_inside_run: assert property (@(posedge clk) disable iff (!arst_n)
		!seq_busy |-> !div_busy) else $error("divider busy while sequencer idle");

endmodule

@@ hw/rtl/skf_div.sv @@
// Radix-2 restoring divider for the gain: (num << FRAC_W) / den, saturated.
// One quotient bit per cycle. Depends on skf_pkg.
module skf_div (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  skf_pkg::word_t num,
	input  skf_pkg::word_t den,
	output logic          busy,
	output skf_pkg::word_t quo,
	output logic          fault
);
	import skf_pkg::*;

	typedef enum logic [1:0] {DIV_IDLE, DIV_RUN, DIV_FIN} div_state_t;

	localparam int CNT_W = $clog2(WIDE_W);

	div_state_t state_q;
	logic [WIDE_W-1:0] work_q;
	logic [WORD_W-1:0] rem_q;
	logic [WORD_W-1:0] den_mag_q;
	logic [CNT_W-1:0] cnt_q;
	logic neg_q;
	word_t quo_q;
	logic fault_q;

	logic [WORD_W:0] trial;
	logic [WORD_W:0] diff;

	always_comb begin
		trial = {rem_q, work_q[WIDE_W-1]};
		diff = trial - {1'b0, den_mag_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DIV_IDLE;
			fault_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			case (state_q)
				DIV_IDLE: begin
					if (start) begin
						if (den == '0) begin
							quo_q <= '0;
							fault_q <= 1'b1;
						end else begin
							fault_q <= 1'b0;
							work_q <= {mag(num), {FRAC_W{1'b0}}};
							rem_q <= '0;
							den_mag_q <= mag(den);
							neg_q <= num[WORD_W-1] ^ den[WORD_W-1];
							cnt_q <= CNT_W'(WIDE_W - 1);
							state_q <= DIV_RUN;
						end
					end
				end
				DIV_RUN: begin
					if (!diff[WORD_W]) begin
						rem_q <= diff[WORD_W-1:0];
						work_q <= {work_q[WIDE_W-2:0], 1'b1};
					end else begin
						rem_q <= trial[WORD_W-1:0];
						work_q <= {work_q[WIDE_W-2:0], 1'b0};
					end
					if (cnt_q == '0) begin
						state_q <= DIV_FIN;
					end else begin
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				DIV_FIN: begin
					quo_q <= sat_mag(work_q, neg_q);
					state_q <= DIV_IDLE;
				end
				default: state_q <= DIV_IDLE;
			endcase
		end
	end

	assign busy = (state_q != DIV_IDLE);
	assign quo = quo_q;
	assign fault = fault_q;

endmodule

@@ hw/rtl/skf_dp.sv @@
// Datapath of the filter: working registers, shared signed multiplier with a
// rounding and saturation stage, and a saturating adder. Depends on skf_pkg.
module skf_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  skf_pkg::ctl_t  ctl,
	input  skf_pkg::cfg_t  cfg,
	input  logic           load,
	input  logic           restart,
	input  skf_pkg::word_t measurement,
	input  skf_pkg::word_t gain,
	output skf_pkg::word_t estimate,
	output skf_pkg::word_t covariance,
	output skf_pkg::word_t ph,
	output skf_pkg::word_t s
);
	import skf_pkg::*;

	word_t x_q, p_q, z_q, xp_q, pp_q, ph_q, s_q, t_q, in_q;
	logic [2*WORD_W-1:0] prod_s1;
	logic neg_s1;
	word_t r_s2;

	word_t op_a, op_b, op_c;
	logic [WIDE_W-1:0] rounded;
	logic signed [WORD_W:0] sum;
	word_t alu_res;

	function automatic word_t pick(input src_t sel, input word_t x, input word_t p,
		input word_t z, input word_t xp, input word_t pp, input word_t phv,
		input word_t sv, input word_t t, input word_t inn, input word_t k,
		input cfg_t c);
		word_t v;
		case (sel)
			SRC_A:   v = c.state_gain;
			SRC_H:   v = c.measure_gain;
			SRC_Q:   v = {1'b0, c.process_noise};
			SRC_R:   v = {1'b0, c.measure_noise};
			SRC_Z:   v = z;
			SRC_X:   v = x;
			SRC_P:   v = p;
			SRC_XP:  v = xp;
			SRC_PP:  v = pp;
			SRC_PH:  v = phv;
			SRC_S:   v = sv;
			SRC_K:   v = k;
			SRC_T:   v = t;
			SRC_IN:  v = inn;
			default: v = '0;
		endcase
		return v;
	endfunction

	always_comb begin
		op_a = pick(ctl.mul_a, x_q, p_q, z_q, xp_q, pp_q, ph_q, s_q, t_q, in_q, gain, cfg);
		op_b = pick(ctl.mul_b, x_q, p_q, z_q, xp_q, pp_q, ph_q, s_q, t_q, in_q, gain, cfg);
		op_c = pick(ctl.alu_c, x_q, p_q, z_q, xp_q, pp_q, ph_q, s_q, t_q, in_q, gain, cfg);
		rounded = WIDE_W'((prod_s1 + (2*WORD_W)'(HALF_LSB)) >> FRAC_W);
		case (ctl.alu)
			ALU_ADD: sum = {op_c[WORD_W-1], op_c} + {r_s2[WORD_W-1], r_s2};
			ALU_SUB: sum = {op_c[WORD_W-1], op_c} - {r_s2[WORD_W-1], r_s2};
			default: sum = {r_s2[WORD_W-1], r_s2};
		endcase
		if (sum[WORD_W] != sum[WORD_W-1]) begin
			alu_res = sum[WORD_W] ? WORD_MIN : WORD_MAX;
		end else begin
			alu_res = sum[WORD_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= mag(op_a) * mag(op_b);
		neg_s1 <= op_a[WORD_W-1] ^ op_b[WORD_W-1];
		r_s2 <= sat_mag(rounded, neg_s1);
		if (load) begin
			z_q <= measurement;
		end
		case (ctl.dest)
			DST_XP:  xp_q <= alu_res;
			DST_T:   t_q <= alu_res;
			DST_IN:  in_q <= alu_res;
			DST_PP:  pp_q <= alu_res;
			DST_PH:  ph_q <= alu_res;
			DST_S:   s_q <= alu_res;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_q <= EST_RST;
			p_q <= {1'b0, COV_RST};
		end else if (load && restart) begin
			x_q <= cfg.initial_estimate;
			p_q <= {1'b0, cfg.initial_covariance};
		end else if (ctl.dest == DST_X) begin
			x_q <= alu_res;
		end else if (ctl.dest == DST_P) begin
			p_q <= alu_res;
		end
	end

	assign estimate = x_q;
	assign covariance = p_q;
	assign ph = ph_q;
	assign s = s_q;

endmodule

@@ hw/rtl/skf_seq.sv @@
// Microcode sequencer: step counter over the program in skf_pkg, with a wait
// on the divider and an end step that holds while the result is not taken.
module skf_seq (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  logic          div_busy,
	input  logic          out_hold,
	output skf_pkg::ctl_t ctl,
	output logic          busy,
	output logic          done
);
	import skf_pkg::*;

	logic [STEP_W-1:0] step_q;
	logic busy_q;
	ctl_t rom;
	logic stall;

	always_comb begin
		rom = ucode(step_q);
		stall = (rom.jump == JMP_WAIT_DIV && div_busy) || (rom.jump == JMP_END && out_hold);
		done = busy_q && rom.jump == JMP_END && !out_hold;
		ctl = busy_q ? rom : CTL_NOP;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			step_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			step_q <= '0;
		end else if (busy_q && !stall) begin
			if (rom.jump == JMP_END) begin
				busy_q <= 1'b0;
				step_q <= '0;
			end else begin
				step_q <= step_q + STEP_W'(1);
			end
		end
	end

	assign busy = busy_q;

endmodule
